/* hw/rtl/wpd_pkg.sv */
// Shared constants and types for the waveform packet deframer.
package wpd_pkg;

  localparam int unsigned WINDOWS_PER_ROI    = 4;
  localparam int unsigned MAX_ROI            = 512;
  localparam int unsigned MAX_WAVEFORMS      = 64;
  localparam int unsigned SAMPLES_PER_WINDOW = 64;

  localparam int unsigned WIN_W = (WINDOWS_PER_ROI > 1) ? $clog2(WINDOWS_PER_ROI) : 1;
  localparam int unsigned ROI_W = $clog2(MAX_ROI + 1);
  localparam int unsigned WF_W  = $clog2(MAX_WAVEFORMS + 1);
  localparam int unsigned SWL_W = $clog2(SAMPLES_PER_WINDOW / 2 + 1);

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned REF_W    = 16;
  localparam int unsigned CHAN_W   = 7;
  localparam int unsigned WINNUM_W = 9;
  localparam int unsigned ROIIDX_W = 9;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned POS_W    = 5;

  localparam logic [WORD_W-1:0] TRUNC_MARKER_RESET = 32'h00be11e2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HEADER_WORD   = 2'd0;
  localparam logic [1:0] CFG_TYPE_WORD     = 2'd1;
  localparam logic [1:0] CFG_TRUNC_MARKER  = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] header_word;
    logic [WORD_W-1:0] waveform_type_word;
    logic [WORD_W-1:0] truncation_marker;
  } cfg_t;

  // Both results of one sample word; they differ only in slot, value, end and last.
  typedef struct packed {
    logic [WORD_W-1:0]   event_number;
    logic [WORD_W-1:0]   module_id;
    logic [REF_W-1:0]    reference_window;
    logic [CHAN_W-1:0]   channel_address;
    logic [WINNUM_W-1:0] window_number;
    logic [ROIIDX_W-1:0] roi_index;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] value_lo;
    logic [SAMPLE_W-1:0] value_hi;
    logic                truncated;
    logic                roi_end;
  } res_pair_t;

endpackage

/* hw/rtl/wpd_parser.sv */
// Packet parser: phase tracking, header capture and sample unpacking for one word.
module wpd_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [wpd_pkg::WORD_W-1:0] in_data_word,
  input  wpd_pkg::cfg_t              cfg,
  output logic                       emit,
  output wpd_pkg::res_pair_t         pair
);

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_SKIP    = 4'd1;
  localparam logic [3:0] PH_TYPE    = 4'd2;
  localparam logic [3:0] PH_MODULE  = 4'd3;
  localparam logic [3:0] PH_REF     = 4'd4;
  localparam logic [3:0] PH_EVENT   = 4'd5;
  localparam logic [3:0] PH_COUNT   = 4'd6;
  localparam logic [3:0] PH_WHDR    = 4'd7;
  localparam logic [3:0] PH_WNS     = 4'd8;
  localparam logic [3:0] PH_SAMPLES = 4'd9;

  localparam logic [wpd_pkg::WIN_W-1:0] WIN_LAST =
    wpd_pkg::WIN_W'(wpd_pkg::WINDOWS_PER_ROI - 1);

  logic [3:0]                    phase_r, phase_nxt;
  logic [wpd_pkg::WORD_W-1:0]    event_r, event_nxt;
  logic                          ev_seen_r, ev_seen_nxt;
  logic [wpd_pkg::WORD_W-1:0]    module_r, module_nxt;
  logic [wpd_pkg::REF_W-1:0]     ref_r, ref_nxt;
  logic [wpd_pkg::WF_W-1:0]      wf_left_r, wf_left_nxt;
  logic [wpd_pkg::SWL_W-1:0]     swl_r, swl_nxt;
  logic [wpd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [15:0]                   whdr_r, whdr_nxt;
  logic [wpd_pkg::ROI_W-1:0]     roi_r, roi_nxt;
  logic [wpd_pkg::WIN_W-1:0]     win_r, win_nxt;
  logic                          trunc_r, trunc_nxt;

  logic [wpd_pkg::WIN_W-1:0]     win_s;
  logic                          trunc_s;
  logic [wpd_pkg::SWL_W-1:0]     swl_dec;
  logic [wpd_pkg::WF_W-1:0]      wf_dec;
  logic                          roi_room;

  // Remaining-waveform count after the current waveform is done.
  assign wf_dec   = (wf_left_r != '0) ? wf_left_r - 1'b1 : wf_left_r;
  assign swl_dec  = (swl_r != '0) ? swl_r - 1'b1 : swl_r;
  assign roi_room = (roi_r < wpd_pkg::ROI_W'(wpd_pkg::MAX_ROI));

  // The truncation marker forces the ROI to its last window before unpacking.
  assign win_s   = (in_data_word == cfg.truncation_marker) ? WIN_LAST : win_r;
  assign trunc_s = (in_data_word == cfg.truncation_marker) ? 1'b1 : trunc_r;

  always_comb begin
    phase_nxt   = phase_r;
    event_nxt   = event_r;
    ev_seen_nxt = ev_seen_r;
    module_nxt  = module_r;
    ref_nxt     = ref_r;
    wf_left_nxt = wf_left_r;
    swl_nxt     = swl_r;
    pos_nxt     = pos_r;
    whdr_nxt    = whdr_r;
    roi_nxt     = roi_r;
    win_nxt     = win_r;
    trunc_nxt   = trunc_r;
    emit        = 1'b0;

    case (phase_r)
      PH_SKIP: begin
        phase_nxt = PH_TYPE;
      end
      PH_TYPE: begin
        if (in_data_word == cfg.waveform_type_word) begin
          phase_nxt = PH_MODULE;
        end else begin
          phase_nxt = (in_data_word == cfg.header_word) ? PH_SKIP : PH_HUNT;
        end
      end
      PH_MODULE: begin
        module_nxt = in_data_word;
        phase_nxt  = PH_REF;
      end
      PH_REF: begin
        ref_nxt   = in_data_word[wpd_pkg::REF_W-1:0];
        phase_nxt = PH_EVENT;
      end
      PH_EVENT: begin
        if (ev_seen_r && (event_r != in_data_word)) begin
          roi_nxt = '0;
        end
        event_nxt   = in_data_word;
        ev_seen_nxt = 1'b1;
        phase_nxt   = PH_COUNT;
      end
      PH_COUNT: begin
        if ((in_data_word == '0) ||
            (in_data_word > wpd_pkg::WORD_W'(wpd_pkg::MAX_WAVEFORMS))) begin
          phase_nxt = PH_HUNT;
        end else begin
          wf_left_nxt = in_data_word[wpd_pkg::WF_W-1:0];
          phase_nxt   = PH_WHDR;
        end
      end
      PH_WHDR: begin
        whdr_nxt  = in_data_word[15:0];
        trunc_nxt = 1'b0;
        phase_nxt = PH_WNS;
      end
      PH_WNS: begin
        if (in_data_word > wpd_pkg::WORD_W'(wpd_pkg::SAMPLES_PER_WINDOW)) begin
          // Oversize waveform: skipped without advancing the window.
          wf_left_nxt = wf_dec;
          phase_nxt   = (wf_dec != '0) ? PH_WHDR : PH_HUNT;
        end else begin
          swl_nxt = in_data_word[wpd_pkg::SWL_W:1];
          pos_nxt = '0;
          if (in_data_word[wpd_pkg::SWL_W:1] == '0) begin
            if (win_r == WIN_LAST) begin
              win_nxt = '0;
              if (roi_room) roi_nxt = roi_r + 1'b1;
            end else begin
              win_nxt = win_r + 1'b1;
            end
            wf_left_nxt = wf_dec;
            phase_nxt   = (wf_dec != '0) ? PH_WHDR : PH_HUNT;
          end else begin
            phase_nxt = PH_SAMPLES;
          end
        end
      end
      PH_SAMPLES: begin
        emit      = roi_room;
        win_nxt   = win_s;
        trunc_nxt = trunc_s;
        pos_nxt   = pos_r + 1'b1;
        swl_nxt   = swl_dec;
        if (swl_dec == '0) begin
          if (win_s == WIN_LAST) begin
            win_nxt = '0;
            if (roi_room) roi_nxt = roi_r + 1'b1;
          end else begin
            win_nxt = win_s + 1'b1;
          end
          wf_left_nxt = wf_dec;
          phase_nxt   = (wf_dec != '0) ? PH_WHDR : PH_HUNT;
        end
      end
      default: begin
        phase_nxt = (in_data_word == cfg.header_word) ? PH_SKIP : PH_HUNT;
      end
    endcase
  end

  always_comb begin
    pair.event_number     = event_r;
    pair.module_id        = module_r;
    pair.reference_window = ref_r;
    pair.channel_address  = whdr_r[15:9];
    pair.window_number    = whdr_r[8:0];
    pair.roi_index        = wpd_pkg::ROIIDX_W'(roi_r);
    pair.slot             = wpd_pkg::SLOT_W'({win_s, 6'b0}) +
                            wpd_pkg::SLOT_W'({pos_r, 1'b0});
    pair.value_lo         = in_data_word[wpd_pkg::SAMPLE_W-1:0];
    pair.value_hi         = in_data_word[16 +: wpd_pkg::SAMPLE_W];
    pair.truncated        = trunc_s;
    pair.roi_end          = (swl_r == wpd_pkg::SWL_W'(1)) && (win_s == WIN_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      event_r   <= '0;
      ev_seen_r <= 1'b0;
      module_r  <= '0;
      ref_r     <= '0;
      wf_left_r <= '0;
      swl_r     <= '0;
      pos_r     <= '0;
      whdr_r    <= '0;
      roi_r     <= '0;
      win_r     <= '0;
      trunc_r   <= 1'b0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      event_r   <= event_nxt;
      ev_seen_r <= ev_seen_nxt;
      module_r  <= module_nxt;
      ref_r     <= ref_nxt;
      wf_left_r <= wf_left_nxt;
      swl_r     <= swl_nxt;
      pos_r     <= pos_nxt;
      whdr_r    <= whdr_nxt;
      roi_r     <= roi_nxt;
      win_r     <= win_nxt;
      trunc_r   <= trunc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_roi_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    roi_r <= wpd_pkg::ROI_W'(wpd_pkg::MAX_ROI))
    else $error("roi counter beyond capacity");

  a_samples_have_words: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SAMPLES) |-> (swl_r != '0) && (wf_left_r != '0))
    else $error("sample phase without words or waveforms left");

  a_emit_only_samples: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (phase_r == PH_SAMPLES))
    else $error("results outside the sample phase");
`endif

endmodule

/* hw/rtl/wpd_out_buf.sv */
// Result register holding one sample word's pair and handing it out one item at a time.
module wpd_out_buf (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  wpd_pkg::res_pair_t           pair,
  output logic                         can_load,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [wpd_pkg::WORD_W-1:0]   out_event_number,
  output logic [wpd_pkg::WORD_W-1:0]   out_module_id,
  output logic [wpd_pkg::REF_W-1:0]    out_reference_window,
  output logic [wpd_pkg::CHAN_W-1:0]   out_channel_address,
  output logic [wpd_pkg::WINNUM_W-1:0] out_window_number,
  output logic [wpd_pkg::ROIIDX_W-1:0] out_roi_index,
  output logic [wpd_pkg::SLOT_W-1:0]   out_sample_index,
  output logic [wpd_pkg::SAMPLE_W-1:0] out_sample_value,
  output logic                         out_truncated,
  output logic                         out_roi_end,
  output logic                         out_last
);

  wpd_pkg::res_pair_t pair_r;
  logic [1:0]         pend_r, pend_nxt;
  logic               second;
  logic               take;

  // pend_r counts the items of the held pair not yet taken.
  assign second   = (pend_r == 2'd1);
  assign take     = out_valid && out_ready;
  assign can_load = (pend_r == 2'd0) || (second && out_ready);

  always_comb begin
    pend_nxt = pend_r;
    if (take) pend_nxt = pend_r - 1'b1;
    if (load) pend_nxt = 2'd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pair_r <= pair;
    end
  end

  assign out_valid            = (pend_r != 2'd0);
  assign out_event_number     = pair_r.event_number;
  assign out_module_id        = pair_r.module_id;
  assign out_reference_window = pair_r.reference_window;
  assign out_channel_address  = pair_r.channel_address;
  assign out_window_number    = pair_r.window_number;
  assign out_roi_index        = pair_r.roi_index;
  assign out_sample_index     = second ? pair_r.slot + 1'b1 : pair_r.slot;
  assign out_sample_value     = second ? pair_r.value_hi : pair_r.value_lo;
  assign out_truncated        = pair_r.truncated;
  assign out_roi_end          = second && pair_r.roi_end;
  assign out_last             = second;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (pend_r == 2'd0) || (second && out_ready))
    else $error("pair loaded over an untaken item");

  a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd2 && out_ready) |=> (pend_r == 2'd1))
    else $error("second item of a pair lost");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (second && out_ready && !load) |=> (pend_r == 2'd0))
    else $error("buffer did not empty after last item");
`endif

endmodule

/* hw/rtl/waveform_packet_deframer.sv */
// Top level of the waveform packet deframer: configuration registers and channel glue.
//
// One readout word is accepted per clock unless a sample word stalls. Header, count and
// waveform-header words give no result and never stall; each sample word gives two items
// (low then high 12-bit sample), paced by the single result port draining the registered
// pair. The next word is taken in the same cycle as the second item of the previous pair,
// so there is no dead cycle between pairs. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does not enforce it.
module waveform_packet_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wpd_pkg::WORD_W-1:0]   in_data_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wpd_pkg::WORD_W-1:0]   out_event_number,
  output logic [wpd_pkg::WORD_W-1:0]   out_module_id,
  output logic [wpd_pkg::REF_W-1:0]    out_reference_window,
  output logic [wpd_pkg::CHAN_W-1:0]   out_channel_address,
  output logic [wpd_pkg::WINNUM_W-1:0] out_window_number,
  output logic [wpd_pkg::ROIIDX_W-1:0] out_roi_index,
  output logic [wpd_pkg::SLOT_W-1:0]   out_sample_index,
  output logic [wpd_pkg::SAMPLE_W-1:0] out_sample_value,
  output logic                         out_truncated,
  output logic                         out_roi_end,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [wpd_pkg::WORD_W-1:0]   cfg_data
);

  wpd_pkg::cfg_t      cfg_r;
  wpd_pkg::res_pair_t pair;
  logic               emit;
  logic               in_fire;
  logic               can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_word        <= '0;
      cfg_r.waveform_type_word <= '0;
      cfg_r.truncation_marker  <= wpd_pkg::TRUNC_MARKER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wpd_pkg::CFG_HEADER_WORD:  cfg_r.header_word        <= cfg_data;
        wpd_pkg::CFG_TYPE_WORD:    cfg_r.waveform_type_word <= cfg_data;
        wpd_pkg::CFG_TRUNC_MARKER: cfg_r.truncation_marker  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Only a word that yields a pair has to wait for room in the result register.
  assign in_ready = can_load || !emit;
  assign in_fire  = in_valid && in_ready;

  wpd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_data_word (in_data_word),
    .cfg          (cfg_r),
    .emit         (emit),
    .pair         (pair)
  );

  wpd_out_buf u_out_buf (
    .clk                  (clk),
    .rst_n                (rst_n),
    .load                 (in_fire && emit),
    .pair                 (pair),
    .can_load             (can_load),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_event_number     (out_event_number),
    .out_module_id        (out_module_id),
    .out_reference_window (out_reference_window),
    .out_channel_address  (out_channel_address),
    .out_window_number    (out_window_number),
    .out_roi_index        (out_roi_index),
    .out_sample_index     (out_sample_index),
    .out_sample_value     (out_sample_value),
    .out_truncated        (out_truncated),
    .out_roi_end          (out_roi_end),
    .out_last             (out_last)
  );

endmodule
